@@ hw/rtl/spnh_pkg.sv @@
// spnh_pkg: shared types, constants and request codes of the next-hop unit.
// No dependencies.
package spnh_pkg;
  localparam int NODES      = 16;
  localparam int NODE_W     = $clog2(NODES);
  localparam int EDGES      = NODES * NODES;
  localparam int EDGE_W     = $clog2(EDGES);
  localparam int COST_WIDTH = 16;
  localparam int PATH_W     = 21;
  localparam int STAMP_W    = 32;
  localparam logic [PATH_W-1:0] PATH_MAX = {PATH_W{1'b1}};
  // edge word: static cost, dynamic cost, update time
  localparam int EWORD_W    = 2 * COST_WIDTH + STAMP_W;

  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_UPDATE  = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;

  localparam logic REG_SELF = 1'b0;
  localparam logic REG_HOST = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_WR_AB, ST_WR_BA,
    ST_SEL, ST_SEL_DONE, ST_REL_RD, ST_REL, ST_OUT_SEL, ST_OUT_WALK, ST_OUT_EMIT
  } state_t;
endpackage

@@ hw/rtl/spnh_ram.sv @@
// spnh_ram: generic single-port-write, single-read RAM with registered read.
// No dependencies.
module spnh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/shortest_path_next_hop_unit.sv @@
// shortest_path_next_hop_unit: top level, sequencer with edge and node memories.
// Depends on spnh_pkg and spnh_ram.
//
//  channel  | handshake          | payload
//  request  | start / busy       | req_type node_a node_b cost_value stamp
//  result   | result_valid       | dest_node next_hop path_cost reachable last
//  config   | cfg_we / cfg_index | cfg_data
//
// Load/update: busy while the edge word is read (ST_RD) and both directions are written.
// Compute: per settled node a select pass over all nodes, then a relax pass over
// the edge memory read port, a last empty select, then the table scan, which
// walks the predecessors of each host hop by hop.
// Reset clears edge valid bits, the settled/reached bits, state, index and config
// registers. Results cannot be stalled; each shows for one cycle with result_valid.
module shortest_path_next_hop_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [3:0]  node_a,
  input  logic [3:0]  node_b,
  input  logic [15:0] cost_value,
  input  logic [31:0] stamp,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output logic        result_valid,
  output logic [3:0]  dest_node,
  output logic [3:0]  next_hop,
  output logic [20:0] path_cost,
  output logic        reachable,
  output logic        last
);
  import spnh_pkg::*;

  state_t state, state_next;

  logic [NODE_W-1:0] self_node;
  logic [15:0]       host_mask;
  logic [EDGES-1:0]  edge_present;   // valid bits of the edge memory
  logic [NODES-1:0]  settled, reached;

  // latched request
  logic [1:0]            rq_type;
  logic [NODE_W-1:0]     rq_a, rq_b;
  logic [COST_WIDTH-1:0] rq_cost;
  logic [STAMP_W-1:0]    rq_stamp;

  // edge memory
  logic              e_we;
  logic [EDGE_W-1:0] e_waddr, e_raddr;
  logic [EWORD_W-1:0] e_wdata, e_rdata, e_new;

  // node memory: distance and predecessor, written together
  logic                  n_we;
  logic [NODE_W-1:0]     n_waddr, n_raddr;
  logic [PATH_W+NODE_W-1:0] n_wdata, n_rdata;

  logic [NODE_W-1:0] idx, best, walk;
  logic              idx_end, have_best;
  logic [PATH_W-1:0] best_dist;
  logic              idx_valid;          // n_rdata belongs to idx_q
  logic [NODE_W-1:0] idx_q;
  logic [PATH_W-1:0] nd;
  logic [PATH_W:0]   sum;
  logic [COST_WIDTH:0] ecost;
  logic [NODE_W-1:0] hop;
  logic              emit_done;

  spnh_ram #(.WIDTH(EWORD_W), .DEPTH(EDGES)) u_edge (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rdata));
  spnh_ram #(.WIDTH(PATH_W + NODE_W), .DEPTH(NODES)) u_node (
    .clk, .we(n_we), .waddr(n_waddr), .wdata(n_wdata), .raddr(n_raddr), .rdata(n_rdata));

  assign busy    = (state != ST_IDLE);
  assign idx_end = (idx == NODE_W'(NODES - 1));

  // edge word for a load or update
  always_comb begin
    if (rq_type == REQ_LOAD) e_new = {rq_cost, {COST_WIDTH{1'b0}}, {STAMP_W{1'b0}}};
    else e_new = {e_rdata[EWORD_W-1 -: COST_WIDTH], rq_cost, rq_stamp};
  end

  // relaxation sum with saturation
  assign ecost = {1'b0, e_rdata[EWORD_W-1 -: COST_WIDTH]}
               + {1'b0, e_rdata[STAMP_W +: COST_WIDTH]};
  assign sum   = {1'b0, best_dist} + (PATH_W+1)'(ecost);
  assign nd    = sum[PATH_W] ? PATH_MAX : sum[PATH_W-1:0];

  // predecessor of the node being walked
  assign hop = n_rdata[NODE_W-1:0];

  // table entry for idx_q is complete this cycle
  assign emit_done = !reached[idx_q] || idx_q == self_node || hop == self_node;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) begin
        if (req_type == REQ_COMPUTE) state_next = ST_SEL;
        else if (req_type == REQ_LOAD || req_type == REQ_UPDATE) state_next = ST_RD;
      end
      ST_RD: begin
        if (rq_type == REQ_LOAD)
          state_next = edge_present[{rq_a, rq_b}] ? ST_IDLE : ST_WR_AB;
        else state_next = edge_present[{rq_a, rq_b}] ? ST_WR_AB : ST_IDLE;
      end
      ST_WR_AB: begin
        if (rq_type == REQ_UPDATE && !(e_rdata[STAMP_W-1:0] < rq_stamp))
          state_next = ST_IDLE;
        else state_next = ST_WR_BA;
      end
      ST_WR_BA: state_next = ST_IDLE;
      ST_SEL: if (idx_valid && idx_q == NODE_W'(NODES - 1)) state_next = ST_SEL_DONE;
      ST_SEL_DONE: state_next = have_best ? ST_REL_RD : ST_OUT_SEL;
      ST_REL_RD: state_next = ST_REL;
      ST_REL: if (idx_valid && idx_q == NODE_W'(NODES - 1)) state_next = ST_SEL;
      ST_OUT_SEL: begin
        if (idx_valid && host_mask[idx_q]) state_next = ST_OUT_WALK;
        else if (idx_valid && idx_q == NODE_W'(NODES - 1)) state_next = ST_IDLE;
      end
      ST_OUT_WALK: state_next = ST_OUT_EMIT;
      ST_OUT_EMIT: begin
        if (emit_done)
          state_next = (idx_q == NODE_W'(NODES - 1)) ? ST_IDLE : ST_OUT_SEL;
        else state_next = ST_OUT_WALK;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory addresses and writes
  always_comb begin
    e_we = 1'b0; e_waddr = {rq_a, rq_b}; e_wdata = e_new; e_raddr = {rq_a, rq_b};
    n_we = 1'b0; n_waddr = idx_q; n_wdata = {nd, best}; n_raddr = idx;
    case (state)
      ST_WR_AB: begin
        e_we = (rq_type == REQ_LOAD) || (e_rdata[STAMP_W-1:0] < rq_stamp);
      end
      ST_WR_BA: begin e_we = 1'b1; e_waddr = {rq_b, rq_a}; e_wdata = e_new; end
      ST_REL_RD, ST_REL: e_raddr = {best, idx};
      ST_OUT_WALK: n_raddr = walk;
      ST_OUT_EMIT: n_raddr = n_rdata[NODE_W-1:0];
      default: ;
    endcase
    if (state == ST_REL && idx_valid && edge_present[{best, idx_q}] && !settled[idx_q]
        && (!reached[idx_q] || n_rdata[PATH_W+NODE_W-1:NODE_W] > nd))
      n_we = 1'b1;
    if (state == ST_IDLE && start && req_type == REQ_COMPUTE) begin
      n_we = 1'b1; n_waddr = self_node; n_wdata = {{PATH_W{1'b0}}, self_node};
    end
  end

  // outputs
  always_comb begin
    result_valid = 1'b0;
    dest_node = 4'(idx_q); next_hop = '0; path_cost = '0; reachable = 1'b0;
    last = (host_mask & ~((16'd2 << idx_q) - 16'd1)) == 16'd0;
    if (state == ST_OUT_EMIT) begin
      if (!reached[idx_q]) result_valid = 1'b1;
      else if (idx_q == self_node) begin
        result_valid = 1'b1; next_hop = 4'(self_node); reachable = 1'b1;
      end else if (hop == self_node) begin
        result_valid = 1'b1; next_hop = 4'(walk); reachable = 1'b1;
        path_cost = best_dist;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; self_node <= '0; host_mask <= '0;
      edge_present <= '0; settled <= '0; reached <= '0;
      idx <= '0; idx_valid <= 1'b0; have_best <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == REG_SELF) self_node <= cfg_data[NODE_W-1:0];
        else host_mask <= cfg_data;
      end
      idx_q <= idx;
      case (state)
        ST_IDLE: if (start) begin
          rq_type <= req_type; rq_a <= node_a; rq_b <= node_b;
          rq_cost <= cost_value[COST_WIDTH-1:0]; rq_stamp <= stamp;
          idx <= '0; idx_valid <= 1'b0; have_best <= 1'b0;
          if (req_type == REQ_COMPUTE) begin
            settled <= '0;
            reached <= NODES'(1) << self_node;
          end
        end
        ST_WR_BA: if (rq_type == REQ_LOAD) begin
          edge_present[{rq_a, rq_b}] <= 1'b1;
          if (rq_a != rq_b) edge_present[{rq_b, rq_a}] <= 1'b1;
        end
        ST_SEL: begin
          if (!idx_end) idx <= idx + 1'b1;
          idx_valid <= 1'b1;
          if (idx_valid && reached[idx_q] && !settled[idx_q] &&
              (!have_best || n_rdata[PATH_W+NODE_W-1:NODE_W] < best_dist)) begin
            have_best <= 1'b1; best <= idx_q;
            best_dist <= n_rdata[PATH_W+NODE_W-1:NODE_W];
          end
        end
        ST_SEL_DONE: begin
          idx <= '0; idx_valid <= 1'b0;
          if (have_best) settled[best] <= 1'b1;
        end
        ST_REL_RD: begin idx <= idx + 1'b1; idx_valid <= 1'b1; end
        ST_REL: begin
          if (n_we) reached[idx_q] <= 1'b1;
          if (idx_valid && idx_q == NODE_W'(NODES - 1)) begin
            idx <= '0; idx_valid <= 1'b0; have_best <= 1'b0;
          end else if (!idx_end) idx <= idx + 1'b1;
        end
        ST_OUT_SEL: begin
          if (idx_valid && host_mask[idx_q]) begin
            // host found: keep its distance for the emitted entry
            idx <= idx_q; idx_valid <= 1'b0; walk <= idx_q;
            best_dist <= n_rdata[PATH_W+NODE_W-1:NODE_W];
          end else begin
            idx_valid <= 1'b1;
            if (!idx_end) idx <= idx + 1'b1;
          end
        end
        ST_OUT_WALK: idx <= idx_q;
        ST_OUT_EMIT: begin
          if (emit_done) begin
            idx <= idx_q + 1'b1; idx_valid <= 1'b0;
          end else begin
            idx <= idx_q; walk <= hop;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
